@@ rtl/ps2_mouse_init_and_packet_receiver_macros.svh @@
// Assertion macros for the PS/2 mouse host block.
// Simulation builds get the checks; synthesis builds get empty bodies.
`ifndef PS2_MOUSE_INIT_AND_PACKET_RECEIVER_MACROS_SVH
`define PS2_MOUSE_INIT_AND_PACKET_RECEIVER_MACROS_SVH

`ifndef SYNTHESIS
// Same-cycle implication, checked at every rising edge outside reset.
`define PS2M_ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("ps2m check failed");
// Next-cycle implication, checked at every rising edge outside reset.
`define PS2M_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("ps2m check failed");
`else
`define PS2M_ASSERT_NOW(label, clk, rst, ante, cons)
`define PS2M_ASSERT_NEXT(label, clk, rst, ante, cons)
`endif

`endif

@@ rtl/ps2m_pkg.sv @@
`default_nettype none

package ps2m_pkg;

   // Request kinds.
   localparam logic REQ_BYTE = 1'b0;
   localparam logic REQ_POLL = 1'b1;

   // Configuration register indexes.
   localparam logic [1:0] CSR_REINIT_INTERVAL = 2'd0;
   localparam logic [1:0] CSR_RESOLUTION_CODE = 2'd1;
   localparam logic [1:0] CSR_SAMPLE_RATE     = 2'd2;

   localparam int unsigned CSR_DATA_WIDTH = 16;

   // Reset values of the configuration registers.
   localparam logic [15:0] REINIT_INTERVAL_RST = 16'd32000;
   localparam logic [1:0]  RESOLUTION_CODE_RST = 2'd3;
   localparam logic [7:0]  SAMPLE_RATE_RST     = 8'h28;

   // Bytes seen on the link.
   localparam logic [7:0] RX_SELF_TEST_OK = 8'hAA;
   localparam logic [7:0] RX_MOUSE_ID     = 8'h00;
   localparam logic [7:0] CMD_RESET       = 8'hFF;
   localparam logic [7:0] CMD_READ_ID     = 8'hF2;
   localparam logic [7:0] CMD_SET_RES     = 8'hE8;
   localparam logic [7:0] CMD_SCALING_1TO1 = 8'hE6;
   localparam logic [7:0] CMD_SET_RATE    = 8'hF3;
   localparam logic [7:0] CMD_ENABLE      = 8'hF4;

   // Link phases.
   typedef enum logic [3:0] {
      PH_WAIT_TEST   = 4'd0,
      PH_WAIT_ID     = 4'd1,
      PH_SEND_RES    = 4'd2,
      PH_SEND_SCALE  = 4'd3,
      PH_SEND_RCMD   = 4'd4,
      PH_SEND_RATE   = 4'd5,
      PH_SEND_ENABLE = 4'd6,
      PH_SKIP_ACK    = 4'd7,
      PH_STATUS      = 4'd8,
      PH_DX          = 4'd9,
      PH_DY          = 4'd10
   } phase_type;

   // One response as it sits in the output register.
   typedef struct packed {
      logic       send_valid;
      logic [7:0] send_byte;
      logic       report_valid;
      logic [7:0] report_status;
      logic [7:0] report_dx;
      logic [7:0] report_dy;
      logic       led_blink;
   } rsp_type;

endpackage

`default_nettype wire

@@ rtl/ps2_mouse_init_and_packet_receiver.sv @@
// Channel | Direction | Accepted when          | Payload
// req     | in        | req_valid & req_ready  | type, rx_byte, timer_now
// rsp     | out       | rsp_valid & rsp_ready  | send, report and LED fields
// csr     | in        | csr_we                 | index, wdata (16 bits)
//
// Each request is handled combinationally: the phase logic works straight off
// the request port and the response lands in a single output register.
// A new request is taken every cycle while the output register is empty or
// is being drained in the same cycle, so the rate is one request per cycle.
// Synchronous active-high reset returns the link to waiting for self-test,
// clears the last reset-attempt time and loads the register defaults.
// A stalled response only holds off new requests; nothing is dropped.
`default_nettype none
`include "ps2_mouse_init_and_packet_receiver_macros.svh"

module ps2_mouse_init_and_packet_receiver (
   input  wire logic        clock,
   input  wire logic        reset,
   // Request channel.
   input  wire logic        req_valid,
   output logic             req_ready,
   input  wire logic        req_type,
   input  wire logic [7:0]  req_rx_byte,
   input  wire logic [15:0] req_timer_now,
   // Response channel.
   output logic             rsp_valid,
   input  wire logic        rsp_ready,
   output logic             rsp_send_valid,
   output logic [7:0]       rsp_send_byte,
   output logic             rsp_report_valid,
   output logic [7:0]       rsp_report_status,
   output logic [7:0]       rsp_report_dx,
   output logic [7:0]       rsp_report_dy,
   output logic             rsp_led_blink,
   // Configuration write port.
   input  wire logic        csr_we,
   input  wire logic [1:0]  csr_index,
   input  wire logic [ps2m_pkg::CSR_DATA_WIDTH-1:0] csr_wdata
);
   import ps2m_pkg::*;

   // Link state.
   phase_type   phase_ff, phase_in;
   logic [15:0] last_reinit_ff, last_reinit_in;
   // The first two report bytes are parked here until the third arrives.
   logic [7:0]  held_status_ff, held_status_in;
   logic [7:0]  held_dx_ff, held_dx_in;

   // Configuration registers.
   logic [15:0] reinit_interval_ff, reinit_interval_in;
   logic [1:0]  resolution_code_ff, resolution_code_in;
   logic [7:0]  sample_rate_ff, sample_rate_in;

   // Output register.
   logic        rsp_valid_ff, rsp_valid_in;
   rsp_type     rsp_ff, rsp_in;

   logic        req_accept;
   logic        is_byte;
   logic        poll_fire;
   logic [15:0] poll_gap;

   // The output register frees up in the same cycle that it is drained.
   assign req_ready  = !rsp_valid_ff || rsp_ready;
   assign req_accept = req_valid && req_ready;
   assign is_byte    = (req_type == REQ_BYTE);

   // A reset attempt goes out once the wrapped distance since the last one
   // reaches the configured interval, and only while waiting for self-test.
   assign poll_gap  = req_timer_now - last_reinit_ff;
   assign poll_fire = !is_byte && (phase_ff == PH_WAIT_TEST)
                      && (poll_gap >= reinit_interval_ff);

   // Next phase. Polls never move the phase; a received byte either steps
   // forward, wraps from the last report byte back to the first, or falls
   // back to waiting for self-test on a bad self-test or ID byte.
   always_comb begin
      phase_in = phase_ff;
      if (req_accept && is_byte) begin
         unique case (phase_ff)
            PH_WAIT_TEST:   phase_in = (req_rx_byte == RX_SELF_TEST_OK) ? PH_WAIT_ID
                                                                        : PH_WAIT_TEST;
            PH_WAIT_ID:     phase_in = (req_rx_byte == RX_MOUSE_ID) ? PH_SEND_RES
                                                                    : PH_WAIT_TEST;
            PH_SEND_RES:    phase_in = PH_SEND_SCALE;
            PH_SEND_SCALE:  phase_in = PH_SEND_RCMD;
            PH_SEND_RCMD:   phase_in = PH_SEND_RATE;
            PH_SEND_RATE:   phase_in = PH_SEND_ENABLE;
            PH_SEND_ENABLE: phase_in = PH_SKIP_ACK;
            PH_SKIP_ACK:    phase_in = PH_STATUS;
            PH_STATUS:      phase_in = PH_DX;
            PH_DX:          phase_in = PH_DY;
            PH_DY:          phase_in = PH_STATUS;
            default:        phase_in = PH_WAIT_TEST;
         endcase
      end
   end

   // Response contents. Every request produces exactly one response; fields
   // that carry nothing stay zero.
   always_comb begin
      rsp_in = '0;
      if (!is_byte) begin
         if (poll_fire) begin
            rsp_in.send_valid = 1'b1;
            rsp_in.send_byte  = CMD_RESET;
         end
      end else begin
         unique case (phase_ff)
            PH_WAIT_TEST: begin
               if (req_rx_byte == RX_SELF_TEST_OK) begin
                  rsp_in.send_valid = 1'b1;
                  rsp_in.send_byte  = CMD_READ_ID;
               end
            end
            PH_WAIT_ID: begin
               if (req_rx_byte == RX_MOUSE_ID) begin
                  rsp_in.send_valid = 1'b1;
                  rsp_in.send_byte  = CMD_SET_RES;
                  rsp_in.led_blink  = 1'b1;
               end
            end
            PH_SEND_RES: begin
               rsp_in.send_valid = 1'b1;
               rsp_in.send_byte  = {6'd0, resolution_code_ff};
            end
            PH_SEND_SCALE: begin
               rsp_in.send_valid = 1'b1;
               rsp_in.send_byte  = CMD_SCALING_1TO1;
            end
            PH_SEND_RCMD: begin
               rsp_in.send_valid = 1'b1;
               rsp_in.send_byte  = CMD_SET_RATE;
            end
            PH_SEND_RATE: begin
               rsp_in.send_valid = 1'b1;
               rsp_in.send_byte  = sample_rate_ff;
            end
            PH_SEND_ENABLE: begin
               rsp_in.send_valid = 1'b1;
               rsp_in.send_byte  = CMD_ENABLE;
            end
            PH_DY: begin
               rsp_in.report_valid  = 1'b1;
               rsp_in.report_status = held_status_ff;
               rsp_in.report_dx     = held_dx_ff;
               rsp_in.report_dy     = req_rx_byte;
            end
            default: begin
               rsp_in = '0;
            end
         endcase
      end
   end

   // Data-path state updates.
   always_comb begin
      last_reinit_in = last_reinit_ff;
      held_status_in = held_status_ff;
      held_dx_in     = held_dx_ff;
      if (req_accept) begin
         if (poll_fire) begin
            last_reinit_in = req_timer_now;
         end
         if (is_byte && (phase_ff == PH_STATUS)) begin
            held_status_in = req_rx_byte;
         end
         if (is_byte && (phase_ff == PH_DX)) begin
            held_dx_in = req_rx_byte;
         end
      end
   end

   // Configuration writes; an index past the last register is ignored.
   always_comb begin
      reinit_interval_in = reinit_interval_ff;
      resolution_code_in = resolution_code_ff;
      sample_rate_in     = sample_rate_ff;
      if (csr_we) begin
         unique case (csr_index)
            CSR_REINIT_INTERVAL: reinit_interval_in = csr_wdata;
            CSR_RESOLUTION_CODE: resolution_code_in = csr_wdata[1:0];
            CSR_SAMPLE_RATE:     sample_rate_in     = csr_wdata[7:0];
            default:             reinit_interval_in = reinit_interval_ff;
         endcase
      end
   end

   assign rsp_valid_in = req_accept || (rsp_valid_ff && !rsp_ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff           <= PH_WAIT_TEST;
         last_reinit_ff     <= '0;
         reinit_interval_ff <= REINIT_INTERVAL_RST;
         resolution_code_ff <= RESOLUTION_CODE_RST;
         sample_rate_ff     <= SAMPLE_RATE_RST;
         rsp_valid_ff       <= 1'b0;
      end else begin
         phase_ff           <= phase_in;
         last_reinit_ff     <= last_reinit_in;
         reinit_interval_ff <= reinit_interval_in;
         resolution_code_ff <= resolution_code_in;
         sample_rate_ff     <= sample_rate_in;
         rsp_valid_ff       <= rsp_valid_in;
      end
   end

   // Payload registers carry no reset.
   always_ff @(posedge clock) begin
      held_status_ff <= held_status_in;
      held_dx_ff     <= held_dx_in;
      if (req_accept) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_send_valid    = rsp_ff.send_valid;
   assign rsp_send_byte     = rsp_ff.send_byte;
   assign rsp_report_valid  = rsp_ff.report_valid;
   assign rsp_report_status = rsp_ff.report_status;
   assign rsp_report_dx     = rsp_ff.report_dx;
   assign rsp_report_dy     = rsp_ff.report_dy;
   assign rsp_led_blink     = rsp_ff.led_blink;

   // A response never carries both a command byte and a report.
   `PS2M_ASSERT_NOW(a_send_xor_report, clock, reset,
      rsp_valid_ff && rsp_ff.report_valid, !rsp_ff.send_valid)
   // The LED pulse only rides along with the set-resolution command.
   `PS2M_ASSERT_NOW(a_blink_with_setres, clock, reset,
      rsp_valid_ff && rsp_ff.led_blink,
      rsp_ff.send_valid && (rsp_ff.send_byte == CMD_SET_RES))
   // A poll taken outside the self-test wait sends nothing and keeps the phase.
   `PS2M_ASSERT_NEXT(a_poll_idle, clock, reset,
      req_accept && (req_type == REQ_POLL) && (phase_ff != PH_WAIT_TEST),
      rsp_valid_ff && !rsp_ff.send_valid && (phase_ff == $past(phase_ff)))
   // The third report byte closes a report and rewinds to the first byte.
   `PS2M_ASSERT_NEXT(a_report_wrap, clock, reset,
      req_accept && (req_type == REQ_BYTE) && (phase_ff == PH_DY),
      rsp_ff.report_valid && (phase_ff == PH_STATUS))

endmodule

`default_nettype wire

@@ test/tb_top.sv @@
module tb_top;
   timeunit 1ns;
   timeprecision 1ps;

   import ps2m_pkg::*;

   // A run that goes this many cycles without any handshake or register
   // write is hung. The slowest legal wait is a sender gap and a receiver
   // stall, so this leaves a wide margin.
   localparam int STALL_LIMIT = 1000;

   logic clock = 1'b0;
   logic reset = 1'b1;

   // Request side, driven on the falling edge.
   logic        req_valid = 1'b0;
   logic        req_ready;
   logic        req_type = REQ_BYTE;
   logic [7:0]  req_rx_byte = 8'h00;
   logic [15:0] req_timer_now = 16'h0000;

   // Response side.
   logic        rsp_valid;
   logic        rsp_ready = 1'b0;
   logic        rsp_send_valid;
   logic [7:0]  rsp_send_byte;
   logic        rsp_report_valid;
   logic [7:0]  rsp_report_status;
   logic [7:0]  rsp_report_dx;
   logic [7:0]  rsp_report_dy;
   logic        rsp_led_blink;

   // Register write port.
   logic                      csr_we = 1'b0;
   logic [1:0]                csr_index = CSR_REINIT_INTERVAL;
   logic [CSR_DATA_WIDTH-1:0] csr_wdata = '0;

   // Our own copy of the link: the host's phase, the time of the last reset
   // attempt, the two report bytes held so far, and the register settings.
   phase_type   link_state = PH_WAIT_TEST;
   logic [15:0] last_attempt = 16'h0000;
   logic [7:0]  held_status_q = 8'h00;
   logic [7:0]  held_dx_q = 8'h00;
   logic [15:0] interval_cfg = REINIT_INTERVAL_RST;
   logic [1:0]  res_cfg = RESOLUTION_CODE_RST;
   logic [7:0]  rate_cfg = SAMPLE_RATE_RST;

   // What the host must do for each accepted request, oldest first.
   rsp_type host_actions_q[$];

   // Idle and stall switches for the two channels.
   bit send_idle_on = 1'b1;
   bit rsp_stall_on = 1'b1;

   int mismatch_count = 0;
   int request_count = 0;
   int response_count = 0;
   int sent_cmd_count = 0;
   int report_count = 0;
   int blink_count = 0;
   int csr_write_count = 0;

   ps2_mouse_init_and_packet_receiver u_dut (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_ready         (req_ready),
      .req_type          (req_type),
      .req_rx_byte       (req_rx_byte),
      .req_timer_now     (req_timer_now),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_send_valid    (rsp_send_valid),
      .rsp_send_byte     (rsp_send_byte),
      .rsp_report_valid  (rsp_report_valid),
      .rsp_report_status (rsp_report_status),
      .rsp_report_dx     (rsp_report_dx),
      .rsp_report_dy     (rsp_report_dy),
      .rsp_led_blink     (rsp_led_blink),
      .csr_we            (csr_we),
      .csr_index         (csr_index),
      .csr_wdata         (csr_wdata)
   );

   initial begin
      forever #1 clock = ~clock;
   end

   // Steps the host link by one request and returns what it must do. A poll
   // only matters while waiting for self-test, and then only once the timer
   // has moved at least the configured interval (with 16-bit wrap) since the
   // last reset attempt. Bytes walk the setup phases; setup acknowledges are
   // not checked, and once in the report phases every third byte completes
   // a movement report.
   function automatic rsp_type advance_link(input logic kind, input logic [7:0] rx,
                                            input logic [15:0] now);
      rsp_type     act;
      phase_type   nxt;
      logic [15:0] gap;
      act = '0;
      if (kind == REQ_POLL) begin
         gap = now - last_attempt;
         if (link_state == PH_WAIT_TEST && gap >= interval_cfg) begin
            last_attempt = now;
            act.send_valid = 1'b1;
            act.send_byte = CMD_RESET;
         end
         return act;
      end
      nxt = phase_type'(link_state + 4'd1);
      case (link_state)
         PH_WAIT_TEST: begin
            if (rx != RX_SELF_TEST_OK) begin
               nxt = PH_WAIT_TEST;
            end else begin
               act.send_valid = 1'b1;
               act.send_byte = CMD_READ_ID;
            end
         end
         PH_WAIT_ID: begin
            if (rx != RX_MOUSE_ID) begin
               nxt = PH_WAIT_TEST;
            end else begin
               act.led_blink = 1'b1;
               act.send_valid = 1'b1;
               act.send_byte = CMD_SET_RES;
            end
         end
         PH_SEND_RES: begin
            act.send_valid = 1'b1;
            act.send_byte = {6'b0, res_cfg};
         end
         PH_SEND_SCALE: begin
            act.send_valid = 1'b1;
            act.send_byte = CMD_SCALING_1TO1;
         end
         PH_SEND_RCMD: begin
            act.send_valid = 1'b1;
            act.send_byte = CMD_SET_RATE;
         end
         PH_SEND_RATE: begin
            act.send_valid = 1'b1;
            act.send_byte = rate_cfg;
         end
         PH_SEND_ENABLE: begin
            act.send_valid = 1'b1;
            act.send_byte = CMD_ENABLE;
         end
         PH_SKIP_ACK: begin
         end
         PH_STATUS: begin
            held_status_q = rx;
         end
         PH_DX: begin
            held_dx_q = rx;
         end
         PH_DY: begin
            act.report_valid = 1'b1;
            act.report_status = held_status_q;
            act.report_dx = held_dx_q;
            act.report_dy = rx;
            nxt = PH_STATUS;
         end
         default: begin
            nxt = PH_WAIT_TEST;
         end
      endcase
      link_state = nxt;
      return act;
   endfunction

   task automatic report_mismatch(input string what);
      $display("MISMATCH at response %0d: %s", response_count, what);
      mismatch_count++;
   endtask

   task automatic check_field(input string name, input logic [7:0] got,
                              input logic [7:0] want);
      if (got !== want) begin
         report_mismatch($sformatf("%s is %h, should be %h", name, got, want));
      end
   endtask

   // Presents one request and holds it until the block takes it. When idling
   // is on, a random burst of empty cycles may come first. The host's action
   // is worked out at the accepting edge so that our copy of the link state
   // is current as soon as this task returns.
   task automatic issue_request(input logic kind, input logic [7:0] rx,
                                input logic [15:0] now);
      int gap;
      if (send_idle_on && $urandom_range(0, 5) == 0) begin
         gap = $urandom_range(1, 19);
         @(negedge clock);
         req_valid <= 1'b0;
         repeat (gap - 1) @(negedge clock);
      end
      @(negedge clock);
      req_valid <= 1'b1;
      req_type <= kind;
      req_rx_byte <= rx;
      req_timer_now <= now;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      host_actions_q.push_back(advance_link(kind, rx, now));
      request_count++;
   endtask

   // The unused field of each request carries random bits all the same.
   task automatic mouse_sends(input logic [7:0] rx);
      issue_request(REQ_BYTE, rx, 16'($urandom));
   endtask

   task automatic timer_poll(input logic [15:0] now);
      issue_request(REQ_POLL, 8'($urandom), now);
   endtask

   // Stops sending and waits for every outstanding response. If one never
   // comes, the watchdog ends the run.
   task automatic drain_link();
      @(negedge clock);
      req_valid <= 1'b0;
      while (host_actions_q.size() != 0) @(posedge clock);
      repeat (2) @(posedge clock);
   endtask

   // Register writes happen only with the link drained.
   task automatic write_csr(input logic [1:0] idx, input logic [CSR_DATA_WIDTH-1:0] wdata);
      drain_link();
      @(negedge clock);
      csr_we <= 1'b1;
      csr_index <= idx;
      csr_wdata <= wdata;
      @(negedge clock);
      csr_we <= 1'b0;
      case (idx)
         CSR_REINIT_INTERVAL: interval_cfg = wdata[15:0];
         CSR_RESOLUTION_CODE: res_cfg = wdata[1:0];
         CSR_SAMPLE_RATE:     rate_cfg = wdata[7:0];
         default: ;
      endcase
      csr_write_count++;
   endtask

   // Reset attempts with the interval left at its reset value: just short
   // of it, exactly on it, the timer extremes, and a distance that wraps.
   task automatic test_reinit_polls();
      timer_poll(16'd0);
      timer_poll(16'd31999);
      timer_poll(16'd32000);
      timer_poll(16'd63999);
      timer_poll(16'd64000);
      timer_poll(16'hFFFF);
      timer_poll(16'd30464);
   endtask

   // Wrong self-test and wrong ID bytes send the link back to waiting; a
   // poll while waiting for the ID does nothing, but one after the fallback
   // attempts a reset again.
   task automatic test_bad_handshake();
      mouse_sends(8'h55);
      mouse_sends(8'h00);
      mouse_sends(8'hFF);
      mouse_sends(RX_SELF_TEST_OK);
      timer_poll(16'(last_attempt + 16'd40000));
      mouse_sends(8'hFF);
      mouse_sends(RX_SELF_TEST_OK);
      mouse_sends(RX_SELF_TEST_OK);
      timer_poll(16'(last_attempt + 16'd40000));
   endtask

   // Several interval settings, the extremes among them, each followed by
   // random traffic that never finishes setup: polls aimed around the
   // threshold, self-test bytes, aborted ID exchanges and noise. The other
   // two registers are written too, with junk in their unused upper bits.
   task automatic test_interval_settings();
      logic [15:0] iv;
      logic [15:0] aux;
      logic [15:0] tm;
      int pick;
      for (int s = 0; s < 6; s++) begin
         case (s)
            0: iv = 16'h0000;
            1: iv = 16'hFFFF;
            2: iv = 16'h0001;
            default: iv = 16'($urandom);
         endcase
         aux = (s < 2) ? iv : 16'($urandom);
         write_csr(CSR_REINIT_INTERVAL, iv);
         write_csr(CSR_RESOLUTION_CODE, aux);
         write_csr(CSR_SAMPLE_RATE, aux);
         send_idle_on = (s != 2);
         rsp_stall_on = (s != 4);
         repeat (110) begin
            pick = $urandom_range(0, 99);
            if (pick < 45) begin
               case ($urandom_range(0, 2))
                  0: tm = 16'($urandom);
                  1: tm = 16'(last_attempt + interval_cfg + $urandom_range(0, 4) + 16'hFFFE);
                  default: tm = 16'(last_attempt + $urandom_range(0, 300));
               endcase
               timer_poll(tm);
            end else if (pick < 75) begin
               mouse_sends(RX_SELF_TEST_OK);
            end else if (link_state == PH_WAIT_ID) begin
               // Anything but the mouse ID, so that setup is never completed here.
               mouse_sends(8'($urandom_range(1, 255)));
            end else begin
               mouse_sends(8'($urandom));
            end
         end
      end
      send_idle_on = 1'b1;
      rsp_stall_on = 1'b1;
   endtask

   // The full setup exchange with random acknowledge bytes, then a few
   // reports with extreme contents and a poll that must do nothing. The
   // link never leaves the report phases after this.
   task automatic test_link_setup();
      write_csr(CSR_RESOLUTION_CODE, 16'($urandom));
      write_csr(CSR_SAMPLE_RATE, 16'($urandom));
      if (link_state == PH_WAIT_ID) begin
         mouse_sends(8'hFF);
      end
      mouse_sends(RX_SELF_TEST_OK);
      mouse_sends(RX_MOUSE_ID);
      mouse_sends(8'($urandom));
      timer_poll(16'(last_attempt + 16'hFFFF));
      repeat (5) mouse_sends(8'($urandom));
      repeat (3) mouse_sends(8'h00);
      repeat (3) mouse_sends(8'hFF);
      timer_poll(16'hFFFF);
      mouse_sends(8'hA5);
      mouse_sends(8'h5A);
      mouse_sends(8'h80);
   endtask

   // Long stream of random report bytes with stray polls. Idling and stalls are
   // re-rolled every hundred requests and switched off for the last stretch.
   task automatic test_movement_reports();
      for (int n = 0; n < 900; n++) begin
         if (n >= 750) begin
            send_idle_on = 1'b0;
            rsp_stall_on = 1'b0;
         end else if (n % 100 == 0) begin
            send_idle_on = ($urandom_range(0, 2) != 0);
            rsp_stall_on = ($urandom_range(0, 2) != 0);
         end
         if ($urandom_range(0, 4) == 0) begin
            timer_poll(16'($urandom));
         end else begin
            mouse_sends(8'($urandom));
         end
      end
   endtask

   // Receiver: either takes every response or holds off in random bursts.
   initial begin : rsp_backpressure
      int hold;
      forever begin
         @(negedge clock);
         if (rsp_stall_on && $urandom_range(0, 5) == 0) begin
            hold = $urandom_range(1, 19);
            rsp_ready <= 1'b0;
            repeat (hold - 1) @(negedge clock);
         end else begin
            rsp_ready <= 1'b1;
         end
      end
   end

   // Every accepted response is matched, field by field, against the oldest
   // host action still outstanding.
   always @(posedge clock) begin : check_host_actions
      rsp_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         response_count++;
         if (host_actions_q.size() == 0) begin
            report_mismatch("response with no request outstanding");
         end else begin
            want = host_actions_q.pop_front();
            check_field("send_valid", rsp_send_valid, want.send_valid);
            check_field("send_byte", rsp_send_byte, want.send_byte);
            check_field("report_valid", rsp_report_valid, want.report_valid);
            check_field("report_status", rsp_report_status, want.report_status);
            check_field("report_dx", rsp_report_dx, want.report_dx);
            check_field("report_dy", rsp_report_dy, want.report_dy);
            check_field("led_blink", rsp_led_blink, want.led_blink);
            if (want.send_valid) sent_cmd_count++;
            if (want.report_valid) report_count++;
            if (want.led_blink) blink_count++;
         end
      end
   end

   // Ends a hung run: counts cycles in which nothing at all is accepted.
   initial begin : watchdog
      int quiet_cycles;
      quiet_cycles = 0;
      while (quiet_cycles < STALL_LIMIT) begin
         @(posedge clock);
         if (reset || csr_we || (req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
            quiet_cycles = 0;
         end else begin
            quiet_cycles++;
         end
      end
      $display("Timeout: no handshake for %0d cycles", STALL_LIMIT);
      $display("*** FAILED ***");
      $finish;
   end

   initial begin
      repeat (12) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      test_reinit_polls();
      test_bad_handshake();
      test_interval_settings();
      test_link_setup();
      test_movement_reports();

      drain_link();
      repeat (4) @(posedge clock);

      $display("Checked %0d requests and %0d responses over %0d register writes.",
               request_count, response_count, csr_write_count);
      $display("Host sent %0d command bytes, gave %0d reports, blinked %0d times.",
               sent_cmd_count, report_count, blink_count);
      if (mismatch_count == 0) begin
         $display("*** PASSED ***");
      end else begin
         $display("*** FAILED ***");
      end
      $finish;
   end

endmodule

@@ ps2_mouse_init_and_packet_receiver.f @@
+incdir+rtl
rtl/ps2m_pkg.sv
rtl/ps2_mouse_init_and_packet_receiver.sv
test/tb_top.sv
